// ===== rtl/sbf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbf_pkg - shared types and constants for the sprite blit framebuffer
// Mode codes, default screen size and the command/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sbf_pkg;

	// default screen geometry in pixels
	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;

	// sprite edge length in pixels and rows
	localparam int SPRITE_SIZE = 8;

	// item fields
	localparam int MODE_W     = 2;
	localparam int POS_W      = 9;
	localparam int ROWS_W     = 64;
	localparam int RADDR_W    = 10;
	localparam int S_TDATA_W  = 96;
	localparam int M_TDATA_W  = 16;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_BLIT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	// leftmost pixel of a byte
	localparam logic [7:0] PIXEL_MSB = 8'h80;

	// controller to datapath
	typedef struct packed {
		logic clear_wr;    // write zero at the clear counter and advance it
		logic capture;     // take the input beat, restart the scan
		logic rd_byte;     // read the scanned framebuffer byte
		logic wr_byte;     // write the scanned byte ORed with its mask
		logic advance;     // step to the next byte of the scan
		logic read_issue;  // read the byte at the read address
		logic out_load;    // load the output register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic clear_last;  // clear counter at the last entry
		logic rect_hit;    // sprite rectangle overlaps the screen
		logic pix_hit;     // pixel position lies on the screen
		logic read_ok;     // read address inside the store
		logic mask_nz;     // scanned byte has pixels to set
		logic scan_last;   // scanned byte is the last of the item
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbf_ctrl - controller for the sprite blit framebuffer
// Sequences the clearing pass, the read-modify-write scan of a blit or
// pixel, the byte read and the output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	input  wire sbf_pkg::dp_sts_t sts,
	output sbf_pkg::dp_cmd_t     cmd
);

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_DISPATCH = 3'd2;
	localparam logic [2:0] ST_RD       = 3'd3;
	localparam logic [2:0] ST_WR       = 3'd4;
	localparam logic [2:0] ST_READ     = 3'd5;
	localparam logic [2:0] ST_DONE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.mode)
					sbf_pkg::MODE_BLIT:  state_nxt = sts.rect_hit ? ST_RD : ST_DONE;
					sbf_pkg::MODE_PIXEL: state_nxt = sts.pix_hit ? ST_RD : ST_DONE;
					sbf_pkg::MODE_READ:  state_nxt = sts.read_ok ? ST_READ : ST_DONE;
					default:             state_nxt = ST_DONE;
				endcase
			end
			ST_RD: begin
				if (sts.mask_nz) begin
					cmd.rd_byte = 1'b1;
					state_nxt   = ST_WR;
				end else begin
					cmd.advance = 1'b1;
					if (sts.scan_last) begin
						state_nxt = ST_DONE;
					end
				end
			end
			ST_WR: begin
				cmd.wr_byte = 1'b1;
				cmd.advance = 1'b1;
				state_nxt   = sts.scan_last ? ST_DONE : ST_RD;
			end
			ST_READ: begin
				cmd.read_issue = 1'b1;
				state_nxt      = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/sbf_datapath.sv =====
// ----------------------------------------------------------------------------
// sbf_datapath - framebuffer memory and byte scan for the sprite blitter
// Holds the item, steps through the sprite rows two bytes a row, builds
// the clipped pixel mask and merges it into the single-port store.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_datapath #(
	parameter int SCREEN_WIDTH  = sbf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = sbf_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [sbf_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire logic [sbf_pkg::MODE_W-1:0]       s_tuser,
	input  wire sbf_pkg::dp_cmd_t                 cmd,
	output sbf_pkg::dp_sts_t                      sts,
	output logic [sbf_pkg::M_TDATA_W-1:0]         m_tdata
);

	localparam int BPR         = (SCREEN_WIDTH + 7) / 8;
	localparam int STORE_BYTES = BPR * SCREEN_HEIGHT;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int W_REM       = SCREEN_WIDTH % 8;
	localparam logic [7:0] LAST_MASK = (W_REM == 0) ? 8'hFF : 8'(8'hFF << (8 - W_REM));
	localparam logic signed [11:0] W_S   = 12'(SCREEN_WIDTH);
	localparam logic signed [11:0] H_S   = 12'(SCREEN_HEIGHT);
	localparam logic signed [11:0] BPR_S = 12'(BPR);
	localparam logic signed [11:0] SPR_S = 12'(sbf_pkg::SPRITE_SIZE);
	localparam logic [2:0]   ROW_LAST = 3'(sbf_pkg::SPRITE_SIZE - 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

	// captured item
	logic [sbf_pkg::MODE_W-1:0]  mode_q;
	logic [sbf_pkg::POS_W-1:0]   px_q;
	logic [sbf_pkg::POS_W-1:0]   py_q;
	logic [sbf_pkg::ROWS_W-1:0]  rows_q;
	logic [sbf_pkg::RADDR_W-1:0] raddr_q;

	// scan position and clear counter
	logic [2:0]    row_q;
	logic          side_q;
	logic [AW-1:0] clr_cnt_q;

	// framebuffer
	logic [7:0]    mem [STORE_BYTES];
	logic [7:0]    mem_q;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic          mem_we;
	logic          mem_re;

	// scan arithmetic
	logic signed [11:0] px_w;
	logic signed [11:0] py_w;
	logic signed [11:0] y_w;
	logic signed [11:0] c0_w;
	logic signed [11:0] c_w;
	logic        [23:0] addr_wide;
	logic        [AW-1:0] scan_addr;
	logic        [7:0]  row_byte;
	logic        [15:0] shifted;
	logic        [7:0]  byte_mask;
	logic        [7:0]  width_mask;
	logic               row_ok;
	logic               col_ok;
	logic               is_read;

	// take the input beat, restart the scan
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= s_tuser;
			px_q    <= s_tdata[8:0];
			py_q    <= s_tdata[17:9];
			rows_q  <= s_tdata[81:18];
			raddr_q <= s_tdata[91:82];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			side_q <= 1'b0;
		end else if (cmd.capture) begin
			row_q  <= '0;
			side_q <= 1'b0;
		end else if (cmd.advance) begin
			side_q <= ~side_q;
			if (side_q) begin
				row_q <= row_q + 3'd1;
			end
		end
	end

	// advance the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// coordinates of the scanned byte
	assign px_w = {{3{px_q[8]}}, px_q};
	assign py_w = {{3{py_q[8]}}, py_q};
	assign y_w  = py_w + $signed({9'b0, row_q});
	assign c0_w = px_w >>> 3;
	assign c_w  = c0_w + $signed({11'b0, side_q});

	assign row_ok = (y_w >= 12'sd0) && (y_w < H_S);
	assign col_ok = (c_w >= 12'sd0) && (c_w < BPR_S);
	assign width_mask = (c_w == BPR_S - 12'sd1) ? LAST_MASK : 8'hFF;

	// pixel mask: sprite row or single pixel, split across two bytes
	assign row_byte  = (mode_q == sbf_pkg::MODE_PIXEL) ? sbf_pkg::PIXEL_MSB
		: rows_q[{row_q, 3'b000} +: 8];
	assign shifted   = {row_byte, 8'h00} >> px_q[2:0];
	assign byte_mask = (row_ok && col_ok)
		? ((side_q ? shifted[7:0] : shifted[15:8]) & width_mask) : 8'h00;

	assign addr_wide = {12'b0, y_w} * {12'b0, BPR_S} + {12'b0, c_w};
	assign scan_addr = addr_wide[AW-1:0];

	// memory port selection
	always_comb begin
		if (cmd.clear_wr) begin
			mem_addr = clr_cnt_q;
		end else if (cmd.read_issue) begin
			mem_addr = AW'(raddr_q);
		end else begin
			mem_addr = scan_addr;
		end
	end

	assign mem_we    = cmd.clear_wr | cmd.wr_byte;
	assign mem_re    = cmd.rd_byte | cmd.read_issue;
	assign mem_wdata = cmd.clear_wr ? 8'h00 : (mem_q | byte_mask);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_q <= mem[mem_addr];
		end
	end

	// status
	assign sts.mode       = mode_q;
	assign sts.clear_last = (clr_cnt_q == CLR_LAST);
	assign sts.rect_hit   = (px_w > -SPR_S) && (px_w < W_S) && (py_w > -SPR_S) && (py_w < H_S);
	assign sts.pix_hit    = (px_w >= 12'sd0) && (px_w < W_S) && (py_w >= 12'sd0) && (py_w < H_S);
	assign sts.read_ok    = (32'(raddr_q) < 32'(STORE_BYTES));
	assign sts.mask_nz    = (byte_mask != 8'h00);
	assign sts.scan_last  = side_q && ((row_q == ROW_LAST) || (mode_q == sbf_pkg::MODE_PIXEL));

	assign is_read = (mode_q == sbf_pkg::MODE_READ) && sts.read_ok;

	// hold the result beat
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata[7:0]  <= is_read ? mem_q : 8'h00;
			m_tdata[8]    <= ((mode_q == sbf_pkg::MODE_BLIT) && sts.rect_hit)
				|| ((mode_q == sbf_pkg::MODE_PIXEL) && sts.pix_hit);
			m_tdata[15:9] <= '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sprite_blit_framebuffer_top.sv =====
// ----------------------------------------------------------------------------
// sprite_blit_framebuffer_top - 1bpp framebuffer with 8x8 sprite blitter
// Blit: scans 16 bytes, a read then a write for each byte with pixels to set,
// skipping the others; set pixel scans two bytes, read fetches one byte.
// Throughput: one item at a time, bounded by the single-port store doing
// a read then a write for each byte a sprite touches.
// Reset: async active low; then a clearing pass of one byte a cycle over
// the whole store (1024 bytes at 128x64) before the first beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_blit_framebuffer_top #(
	parameter int SCREEN_WIDTH  = sbf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = sbf_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// pos_x[8:0], pos_y[17:9], sprite_rows[81:18], read_address[91:82]
	input  wire logic [sbf_pkg::S_TDATA_W-1:0] s_tdata,
	// mode[1:0]
	input  wire logic [sbf_pkg::MODE_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// read_data[7:0], drawn[8]
	output logic [sbf_pkg::M_TDATA_W-1:0]      m_tdata
);

	sbf_pkg::dp_cmd_t cmd;
	sbf_pkg::dp_sts_t sts;

	sbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbf_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata)
	);

`ifndef SYNTHESIS
	// the single store port never reads and writes a scan byte together
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_byte && cmd.wr_byte))
		else $error("scan read and write in the same cycle");

	// a result never overwrites a beat still waiting
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output register loaded while occupied");

	// a loaded result shows as a valid beat next cycle
	a_out_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

	// no beat is taken during the clearing pass
	a_clear_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !s_tready)
		else $error("input taken while clearing");

	// every byte write follows a read of the same byte
	a_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_byte |-> $past(cmd.rd_byte))
		else $error("byte written without a preceding read");
`endif

endmodule

`default_nettype wire
